/* sv/summed_area_rect_stats_core_macros.svh */
// Assertion macros used by the summed-area statistics datapath.
`ifndef SUMMED_AREA_RECT_STATS_CORE_MACROS_SVH
`define SUMMED_AREA_RECT_STATS_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet during rst
`define SARSC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, quiet during rst
`define SARSC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/sarsc_pkg.sv */
// Shared types and constants of the summed-area statistics core.
`timescale 1ns / 1ps
package sarsc_pkg;

  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;

  localparam int CFG_W    = 9;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;
  // register indexes
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  localparam int PIX_W    = 8;
  localparam int SUM_W    = 24;
  localparam int SQ_W     = 32;
  localparam int PROD_W   = 48;
  localparam int SS_W     = 50;
  localparam int AREA_W   = 17;
  localparam int AVG_W    = 8;
  localparam int SCORE_W  = 34;
  localparam int DIV_STEPS = SS_W;

  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 248;

  // input modes
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // corner codes
  localparam logic [1:0] CORNER_RB = 2'd0;
  localparam logic [1:0] CORNER_LB = 2'd1;
  localparam logic [1:0] CORNER_RT = 2'd2;
  localparam logic [1:0] CORNER_LT = 2'd3;

  // divider operand select
  localparam logic [1:0] DIV_SS = 2'd0;
  localparam logic [1:0] DIV_R  = 2'd1;
  localparam logic [1:0] DIV_G  = 2'd2;
  localparam logic [1:0] DIV_B  = 2'd3;

  // one table entry: three channel sums and three sums of squares
  typedef struct packed {
    logic [SQ_W-1:0]  sq_b;
    logic [SQ_W-1:0]  sq_g;
    logic [SQ_W-1:0]  sq_r;
    logic [SUM_W-1:0] sum_b;
    logic [SUM_W-1:0] sum_g;
    logic [SUM_W-1:0] sum_r;
  } entry_t;

  typedef struct packed {
    logic       accept_load;
    logic       accept_query;
    logic       rd_prev;
    logic       wr;
    logic       rd_corner;
    logic [1:0] corner;
    logic       t1_load;
    logic       sq_mul;
    logic       sq_add;
    logic [1:0] sq_ch;
    logic       div_load;
    logic       div_step;
    logic       div_store;
    logic [1:0] div_sel;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic query_bad;
    logic out_busy;
  } status_t;

endpackage

/* sv/sarsc_mem.sv */
// Single-port table memory with registered read data.
`timescale 1ns / 1ps
module sarsc_mem #(
  parameter int DEPTH  = 65536,
  parameter int ADDR_W = 16,
  parameter int DATA_W = 168
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // one access a cycle: write, or read into the output register
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else begin
      rdata <= mem[addr];
    end
  end

endmodule

/* sv/sarsc_ctrl.sv */
// Sequencer for loads and rectangle queries.
`timescale 1ns / 1ps
module sarsc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              mode,
  output logic              s_tready,
  input  sarsc_pkg::status_t st,
  output sarsc_pkg::cmd_t    cmd
);
  import sarsc_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LD_RD = 3'd1;
  localparam logic [2:0] S_LD_WR = 3'd2;
  localparam logic [2:0] S_Q_RD  = 3'd3;
  localparam logic [2:0] S_Q_ACC = 3'd4;
  localparam logic [2:0] S_Q_SQ  = 3'd5;
  localparam logic [2:0] S_Q_DIV = 3'd6;
  localparam logic [2:0] S_Q_OUT = 3'd7;

  localparam logic [5:0] DIV_LAST = 6'(DIV_STEPS + 1);

  logic [2:0] state, state_next;
  logic [5:0] cnt, cnt_next;
  logic [1:0] sel, sel_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      sel   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      sel   <= sel_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    sel_next   = sel;
    s_tready   = 1'b0;
    cmd        = '0;
    cmd.corner  = cnt[1:0];
    cmd.sq_ch   = cnt[1:0];
    cmd.div_sel = sel;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        cnt_next = '0;
        sel_next = DIV_SS;
        if (s_tvalid) begin
          if (mode == MODE_LOAD) begin
            cmd.accept_load = 1'b1;
            state_next      = S_LD_RD;
          end else begin
            cmd.accept_query = 1'b1;
            state_next       = st.query_bad ? S_Q_OUT : S_Q_RD;
          end
        end
      end
      S_LD_RD: begin
        cmd.rd_prev = 1'b1;
        state_next  = S_LD_WR;
      end
      S_LD_WR: begin
        cmd.wr     = 1'b1;
        state_next = S_IDLE;
      end
      S_Q_RD: begin
        cmd.rd_corner = 1'b1;
        cnt_next      = cnt + 6'd1;
        if (cnt[1:0] == CORNER_LT) begin
          cnt_next   = '0;
          state_next = S_Q_ACC;
        end
      end
      S_Q_ACC: begin
        state_next = S_Q_SQ;
      end
      S_Q_SQ: begin
        cmd.t1_load = (cnt == 6'd0);
        cmd.sq_mul  = (cnt < 6'd3);
        cmd.sq_add  = (cnt != 6'd0);
        cnt_next    = cnt + 6'd1;
        if (cnt == 6'd3) begin
          cnt_next   = '0;
          state_next = S_Q_DIV;
        end
      end
      S_Q_DIV: begin
        cmd.div_load  = (cnt == 6'd0);
        cmd.div_step  = (cnt != 6'd0) && (cnt != DIV_LAST);
        cmd.div_store = (cnt == DIV_LAST);
        cnt_next      = cnt + 6'd1;
        if (cnt == DIV_LAST) begin
          cnt_next = '0;
          sel_next = sel + 2'd1;
          if (sel == DIV_B) begin
            state_next = S_Q_OUT;
          end
        end
      end
      S_Q_OUT: begin
        if (!st.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* sv/sarsc_dp.sv */
// Datapath: load state, table access, rectangle sums, divider and result word.
`timescale 1ns / 1ps
`include "summed_area_rect_stats_core_macros.svh"
module sarsc_dp #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [sarsc_pkg::CFG_W-1:0]         image_width,
  input  logic [sarsc_pkg::CFG_W-1:0]         image_height,
  input  logic                                cfg_wr,
  input  logic [sarsc_pkg::IN_TDATA_W-1:0]    s_tdata,
  input  sarsc_pkg::cmd_t                     cmd,
  output sarsc_pkg::status_t                  st,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [sarsc_pkg::OUT_TDATA_W-1:0]   m_tdata,
  output logic                                m_tuser
);
  import sarsc_pkg::*;

  localparam int CELLS  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int XW     = $clog2(MAX_WIDTH + 1);
  localparam int YW     = $clog2(MAX_HEIGHT + 1);
  localparam int ENTRY_W = $bits(entry_t);

  // input fields
  logic [PIX_W-1:0] red, green, blue, left, top, right, bottom;
  assign red    = s_tdata[7:0];
  assign green  = s_tdata[15:8];
  assign blue   = s_tdata[23:16];
  assign left   = s_tdata[31:24];
  assign top    = s_tdata[39:32];
  assign right  = s_tdata[47:40];
  assign bottom = s_tdata[55:48];

  // effective dimensions: zero acts as one, above the maximum clamps
  logic [XW-1:0] w_eff;
  logic [YW-1:0] h_eff;
  always_comb begin
    if (image_width == '0) w_eff = XW'(1);
    else if (32'(image_width) > 32'(MAX_WIDTH)) w_eff = XW'(MAX_WIDTH);
    else w_eff = XW'(image_width);
    if (image_height == '0) h_eff = YW'(1);
    else if (32'(image_height) > 32'(MAX_HEIGHT)) h_eff = YW'(MAX_HEIGHT);
    else h_eff = YW'(image_height);
  end

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [31:0] x, input logic [31:0] y);
    logic [31:0] a;
    a = y * 32'(MAX_WIDTH) + x;
    return a[ADDR_W-1:0];
  endfunction

  // ---------------- load state ----------------
  logic [XW-1:0]    col, x_reg;
  logic [YW-1:0]    row, y_reg;
  logic             complete;
  logic [SUM_W-1:0] run_r, run_g, run_b;
  logic [SQ_W-1:0]  run_qr, run_qg, run_qb;
  entry_t           wv;

  logic             restart;
  logic [XW-1:0]    x_now, col_inc;
  logic [YW-1:0]    y_now, row_inc;
  entry_t           run_new;

  always_comb begin
    restart = complete || (col >= w_eff) || (row >= h_eff);
    x_now   = restart ? '0 : col;
    y_now   = restart ? '0 : row;
    col_inc = x_now + XW'(1);
    row_inc = y_now + YW'(1);
    run_new.sum_r = (restart ? '0 : run_r) + SUM_W'(red);
    run_new.sum_g = (restart ? '0 : run_g) + SUM_W'(green);
    run_new.sum_b = (restart ? '0 : run_b) + SUM_W'(blue);
    run_new.sq_r  = (restart ? '0 : run_qr) + SQ_W'({8'd0, red} * {8'd0, red});
    run_new.sq_g  = (restart ? '0 : run_qg) + SQ_W'({8'd0, green} * {8'd0, green});
    run_new.sq_b  = (restart ? '0 : run_qb) + SQ_W'({8'd0, blue} * {8'd0, blue});
  end

  // raster position, row running sums, image complete flag
  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      col      <= '0;
      row      <= '0;
      complete <= 1'b0;
      run_r    <= '0;
      run_g    <= '0;
      run_b    <= '0;
      run_qr   <= '0;
      run_qg   <= '0;
      run_qb   <= '0;
    end else if (cmd.accept_load) begin
      complete <= 1'b0;
      if (col_inc >= w_eff) begin
        col    <= '0;
        run_r  <= '0;
        run_g  <= '0;
        run_b  <= '0;
        run_qr <= '0;
        run_qg <= '0;
        run_qb <= '0;
        if (row_inc >= h_eff) begin
          row      <= '0;
          complete <= 1'b1;
        end else begin
          row <= row_inc;
        end
      end else begin
        col    <= col_inc;
        row    <= y_now;
        run_r  <= run_new.sum_r;
        run_g  <= run_new.sum_g;
        run_b  <= run_new.sum_b;
        run_qr <= run_new.sq_r;
        run_qg <= run_new.sq_g;
        run_qb <= run_new.sq_b;
      end
    end
  end

  // pixel being written
  always_ff @(posedge clk) begin
    if (cmd.accept_load) begin
      x_reg <= x_now;
      y_reg <= y_now;
      wv    <= run_new;
    end
  end

  // ---------------- query capture ----------------
  logic [PIX_W-1:0]  q_l, q_t, q_r, q_b;
  logic [AREA_W-1:0] area;
  logic              bad;
  logic              bad_now;

  assign bad_now = !complete || (left > right) || (top > bottom)
                || (32'(right) >= 32'(w_eff)) || (32'(bottom) >= 32'(h_eff));
  assign st.query_bad = bad_now;

  always_ff @(posedge clk) begin
    if (cmd.accept_query) begin
      q_l  <= left;
      q_t  <= top;
      q_r  <= right;
      q_b  <= bottom;
      bad  <= bad_now;
      area <= AREA_W'(9'(right) - 9'(left) + 9'd1) * AREA_W'(9'(bottom) - 9'(top) + 9'd1);
    end
  end

  // ---------------- table memory ----------------
  logic              mem_we;
  logic [ADDR_W-1:0] mem_addr;
  entry_t            mem_wdata;
  logic [ENTRY_W-1:0] mem_rdata_raw;
  entry_t            mem_rdata;
  entry_t            prev;
  logic [PIX_W-1:0]  cx, cy;

  assign mem_rdata = entry_t'(mem_rdata_raw);
  assign prev      = (y_reg != '0) ? mem_rdata : '0;

  always_comb begin
    cx = ((cmd.corner == CORNER_LB) || (cmd.corner == CORNER_LT)) ? q_l - 8'd1 : q_r;
    cy = ((cmd.corner == CORNER_RT) || (cmd.corner == CORNER_LT)) ? q_t - 8'd1 : q_b;
    mem_we = cmd.wr;
    if (cmd.rd_corner) begin
      mem_addr = cell_addr(32'(cx), 32'(cy));
    end else if (cmd.rd_prev) begin
      mem_addr = cell_addr(32'(x_reg), 32'(y_reg) - 32'd1);
    end else begin
      mem_addr = cell_addr(32'(x_reg), 32'(y_reg));
    end
    mem_wdata.sum_r = wv.sum_r + prev.sum_r;
    mem_wdata.sum_g = wv.sum_g + prev.sum_g;
    mem_wdata.sum_b = wv.sum_b + prev.sum_b;
    mem_wdata.sq_r  = wv.sq_r + prev.sq_r;
    mem_wdata.sq_g  = wv.sq_g + prev.sq_g;
    mem_wdata.sq_b  = wv.sq_b + prev.sq_b;
  end

  sarsc_mem #(
    .DEPTH  (CELLS),
    .ADDR_W (ADDR_W),
    .DATA_W (ENTRY_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata_raw)
  );

  // ---------------- corner accumulation ----------------
  logic       pend;
  logic [1:0] pend_corner;
  logic       use_c, neg_c;
  entry_t     acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      pend <= cmd.rd_corner;
    end
  end

  always_ff @(posedge clk) begin
    pend_corner <= cmd.corner;
  end

  always_comb begin
    case (pend_corner)
      CORNER_RB: use_c = 1'b1;
      CORNER_LB: use_c = (q_l != '0);
      CORNER_RT: use_c = (q_t != '0);
      CORNER_LT: use_c = (q_l != '0) && (q_t != '0);
      default:   use_c = 1'b0;
    endcase
    neg_c = (pend_corner == CORNER_LB) || (pend_corner == CORNER_RT);
  end

  // inclusion-exclusion over the four corners, modular
  always_ff @(posedge clk) begin
    if (cmd.accept_query) begin
      acc <= '0;
    end else if (pend && use_c) begin
      if (neg_c) begin
        acc.sum_r <= acc.sum_r - mem_rdata.sum_r;
        acc.sum_g <= acc.sum_g - mem_rdata.sum_g;
        acc.sum_b <= acc.sum_b - mem_rdata.sum_b;
        acc.sq_r  <= acc.sq_r - mem_rdata.sq_r;
        acc.sq_g  <= acc.sq_g - mem_rdata.sq_g;
        acc.sq_b  <= acc.sq_b - mem_rdata.sq_b;
      end else begin
        acc.sum_r <= acc.sum_r + mem_rdata.sum_r;
        acc.sum_g <= acc.sum_g + mem_rdata.sum_g;
        acc.sum_b <= acc.sum_b + mem_rdata.sum_b;
        acc.sq_r  <= acc.sq_r + mem_rdata.sq_r;
        acc.sq_g  <= acc.sq_g + mem_rdata.sq_g;
        acc.sq_b  <= acc.sq_b + mem_rdata.sq_b;
      end
    end
  end

  // ---------------- squared sums ----------------
  logic [SUM_W-1:0]   sq_in;
  logic [PROD_W-1:0]  prod;
  logic [SS_W-1:0]    ss;
  logic [SCORE_W-1:0] t1;

  always_comb begin
    case (cmd.sq_ch)
      2'd0:    sq_in = acc.sum_r;
      2'd1:    sq_in = acc.sum_g;
      default: sq_in = acc.sum_b;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.sq_mul) begin
      prod <= PROD_W'(sq_in) * PROD_W'(sq_in);
    end
    if (cmd.t1_load) begin
      t1 <= SCORE_W'(acc.sq_r) + SCORE_W'(acc.sq_g) + SCORE_W'(acc.sq_b);
    end
    if (cmd.accept_query) begin
      ss <= '0;
    end else if (cmd.sq_add) begin
      ss <= ss + SS_W'(prod);
    end
  end

  // ---------------- restoring divider, one quotient bit a cycle ----------------
  logic [AREA_W:0]    rem, trial;
  logic [SS_W-1:0]    dq;
  logic [AVG_W-1:0]   avg_r, avg_g, avg_b;
  logic [SCORE_W-1:0] score;

  assign trial = {rem[AREA_W-1:0], dq[SS_W-1]};

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      rem <= '0;
      case (cmd.div_sel)
        DIV_SS:  dq <= ss;
        DIV_R:   dq <= SS_W'(acc.sum_r);
        DIV_G:   dq <= SS_W'(acc.sum_g);
        default: dq <= SS_W'(acc.sum_b);
      endcase
    end else if (cmd.div_step) begin
      if (trial >= {1'b0, area}) begin
        rem <= trial - {1'b0, area};
        dq  <= {dq[SS_W-2:0], 1'b1};
      end else begin
        rem <= trial;
        dq  <= {dq[SS_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_store) begin
      case (cmd.div_sel)
        DIV_SS:  score <= (SS_W'(t1) >= dq) ? SCORE_W'(SS_W'(t1) - dq) : '0;
        DIV_R:   avg_r <= dq[AVG_W-1:0];
        DIV_G:   avg_g <= dq[AVG_W-1:0];
        default: avg_b <= dq[AVG_W-1:0];
      endcase
    end
  end

  // ---------------- output register ----------------
  assign st.out_busy = m_tvalid && !m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tuser <= bad;
      if (bad) begin
        m_tdata <= '0;
      end else begin
        m_tdata <= {5'd0, score, avg_b, avg_g, avg_r, area,
                    acc.sq_b, acc.sq_g, acc.sq_r, acc.sum_b, acc.sum_g, acc.sum_r};
      end
    end
  end

  // ---------------- checks ----------------
  `SARSC_ASSERT_IMP(a_out_slot_free, cmd.out_load, !m_tvalid || m_tready, "result word overwritten")
  `SARSC_ASSERT_IMP(a_one_access, cmd.wr, !cmd.rd_corner && !cmd.rd_prev, "table read and write together")
  `SARSC_ASSERT_NXT(a_rem_below_area, cmd.div_step, rem < {1'b0, area}, "divider remainder not reduced")
  `SARSC_ASSERT_IMP(a_area_nonzero, cmd.div_load, area != '0, "division by zero area")

endmodule

/* sv/summed_area_rect_stats_core.sv */
// Top level of the summed-area rectangle statistics core.
// Pixels (tuser = 0) are loaded in raster order into summed-area tables of the
// red, green and blue values and their squares; once a whole image_width x
// image_height image is in, a rectangle query (tuser = 1) returns channel sums,
// sums of squares, area, floor averages and the squared-deviation score, or a
// word flagged bad_rect with all other fields zero. In a load the single-port
// table memory is read for the entry above, then written. A valid query does
// 4 corner reads, squares the channel sums and runs four divisions in the
// bit-serial divider; a refused query goes straight to the result word.
// Loads are taken while a result word waits on the output. The tables need no
// clearing after reset. Register writes restart the image; the user makes them
// only while the core is idle; the core itself has no check on this.
`timescale 1ns / 1ps
module summed_area_rect_stats_core #(
  parameter int MAX_WIDTH  = sarsc_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = sarsc_pkg::MAX_HEIGHT_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // APB configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [sarsc_pkg::PADDR_W-1:0]     paddr,
  input  logic [sarsc_pkg::PDATA_W-1:0]     pwdata,
  output logic [sarsc_pkg::PDATA_W-1:0]     prdata,
  output logic                              pready,
  // input stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // red[7:0] green[15:8] blue[23:16] left[31:24] top[39:32] right[47:40] bottom[55:48]
  input  logic [sarsc_pkg::IN_TDATA_W-1:0]  s_tdata,
  // mode[0]
  input  logic                              s_tuser,
  // result stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // sum_red[23:0] sum_green[47:24] sum_blue[71:48] sumsq_red[103:72]
  // sumsq_green[135:104] sumsq_blue[167:136] area[184:168] avg_red[192:185]
  // avg_green[200:193] avg_blue[208:201] score[242:209], zero pad to 247
  output logic [sarsc_pkg::OUT_TDATA_W-1:0] m_tdata,
  // bad_rect[0]
  output logic                              m_tuser
);
  import sarsc_pkg::*;

  logic [CFG_W-1:0] image_width, image_height;
  logic             cfg_wr;
  logic             reg_sel;
  cmd_t             cmd;
  status_t          st;

  // configuration registers
  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= CFG_W'(256);
      image_height <= CFG_W'(256);
    end else if (cfg_wr) begin
      if (reg_sel == REG_IMAGE_WIDTH) begin
        image_width <= pwdata[CFG_W-1:0];
      end else begin
        image_height <= pwdata[CFG_W-1:0];
      end
    end
  end

  assign prdata = (reg_sel == REG_IMAGE_WIDTH) ? PDATA_W'(image_width)
                                               : PDATA_W'(image_height);

  sarsc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .mode     (s_tuser),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  sarsc_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .image_width  (image_width),
    .image_height (image_height),
    .cfg_wr       (cfg_wr),
    .s_tdata      (s_tdata),
    .cmd          (cmd),
    .st           (st),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tuser      (m_tuser)
  );

endmodule
